[rtl/core/sv39_page_table_walker_macros.svh]
// Assertion macros for the Sv39 page table walker checker
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH

// clocked assertion, off while reset is low
`define PTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked implication, off while reset is low
`define PTW_ASSERT_IMP(label, ante, cons, msg) \
  `PTW_ASSERT(label, (ante) |-> (cons), msg)

// clocked next-cycle implication, off while reset is low
`define PTW_ASSERT_NXT(label, ante, cons, msg) \
  `PTW_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/core/ptw_pkg.sv]
// Shared types and constants for the Sv39 page table walker
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int NUM_TABLES = 64;
  localparam int VPN_W      = 9;
  localparam int TBL_W      = $clog2(NUM_TABLES);
  localparam int ADDR_W     = TBL_W + VPN_W;
  localparam int ALLOC_W    = $clog2(NUM_TABLES + 1);
  localparam int PPN_W      = 44;
  localparam int FLAG_W     = 10;
  localparam int PTE_W      = PPN_W + FLAG_W;
  localparam int VA_W       = 39;
  localparam int PA_W       = 56;
  localparam int OFF_W      = 12;
  localparam int ROOT_W     = 6;
  localparam int APB_DW     = 64;
  localparam int APB_AW     = 4;
  localparam int LVL_W      = 2;

  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_ROOT = 2'd2;

  localparam logic CFG_ROOT = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_MAP    = 1'b1;

  typedef struct packed {
    logic              action;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [FLAG_W-1:0] pte_flags;
  } ptw_in_t;

  typedef struct packed {
    logic [PA_W-1:0]   result_phys;
    logic [FLAG_W-1:0] result_flags;
    logic              mapped;
    logic              status;
  } ptw_out_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root_sel;
    logic [PPN_W-1:0]  table_base_ppn;
  } ptw_cfg_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PTE_W-1:0]  wdata;
  } ptw_mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } ptw_state_e;

endpackage

[rtl/core/ptw_store.sv]
// Single-port PTE store with registered read data
`timescale 1ns / 1ps

module ptw_store
  import ptw_pkg::*;
(
  input  logic             clk_i,
  input  ptw_mem_req_t     req_i,
  output logic [PTE_W-1:0] rdata_o
);

  logic [PTE_W-1:0] mem [2**ADDR_W];
  logic [PTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ptw_cfg.sv]
// APB configuration registers: root table and table base PPN
`timescale 1ns / 1ps

module ptw_cfg
  import ptw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output ptw_cfg_t          cfg_o
);

  logic [ROOT_W-1:0] root_q, root_d;
  logic [PPN_W-1:0]  base_q, base_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    root_d = root_q;
    base_d = base_q;
    if (wr_en) begin
      unique case (paddr[3])
        CFG_ROOT: root_d = pwdata[ROOT_W-1:0];
        CFG_BASE: base_d = pwdata[PPN_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      CFG_ROOT: prdata = APB_DW'(root_q);
      CFG_BASE: prdata = APB_DW'(base_q);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      base_q <= '0;
    end else begin
      root_q <= root_d;
      base_q <= base_d;
    end
  end

  assign cfg_o.root_sel       = root_q;
  assign cfg_o.table_base_ppn = base_q;

endmodule

[rtl/core/ptw_seq.sv]
// Walk sequencer: clear pass, level walk, table allocation and result
`timescale 1ns / 1ps

module ptw_seq
  import ptw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ptw_in_t          item_i,
  input  ptw_cfg_t         cfg_i,
  output ptw_mem_req_t     mem_req_o,
  input  logic [PTE_W-1:0] mem_rdata_i,
  output logic             result_valid_o,
  output ptw_out_t         result_o
);

  ptw_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ALLOC_W-1:0] alloc_q, alloc_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [TBL_W-1:0]  tbl_q, tbl_d;
  ptw_in_t           item_q, item_d;
  ptw_out_t          res_q, res_d;

  logic              accept;
  logic              root_bad;
  logic [PPN_W-1:0]  root_ext;
  logic [VPN_W-1:0]  vpn;
  logic [ADDR_W-1:0] cur_addr;
  logic              e_valid;
  logic [PPN_W-1:0]  e_ppn;
  logic [PPN_W-1:0]  nxt;
  logic              nxt_ok;
  logic              pool_full;
  logic              is_leaf;
  logic [PTE_W-1:0]  new_pte;

  assign accept   = start & (state_q == ST_IDLE);
  assign root_ext = PPN_W'(cfg_i.root_sel);
  assign root_bad = root_ext >= PPN_W'(NUM_TABLES);

  always_comb begin
    case (lvl_q)
      LVL_ROOT: vpn = item_q.virt_addr[OFF_W+2*VPN_W +: VPN_W];
      LVL_MID:  vpn = item_q.virt_addr[OFF_W+VPN_W +: VPN_W];
      LVL_LEAF: vpn = item_q.virt_addr[OFF_W +: VPN_W];
      default:  vpn = '0;
    endcase
  end

  assign cur_addr  = {tbl_q, vpn};
  assign e_valid   = mem_rdata_i[0];
  assign e_ppn     = mem_rdata_i[PTE_W-1:FLAG_W];
  // shared pointer unit: subtract base, range check
  assign nxt       = e_ppn - cfg_i.table_base_ppn;
  assign nxt_ok    = nxt < PPN_W'(NUM_TABLES);
  assign pool_full = alloc_q >= ALLOC_W'(NUM_TABLES);
  assign is_leaf   = lvl_q == LVL_LEAF;
  assign new_pte   = {cfg_i.table_base_ppn + PPN_W'(alloc_q), FLAG_W'(1)};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = root_bad ? ST_DONE : ST_READ;
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL: begin
        if (is_leaf) begin
          state_d = ST_DONE;
        end else if (!e_valid) begin
          state_d = (item_q.action == ACT_MAP && !pool_full) ? ST_READ : ST_DONE;
        end else begin
          state_d = nxt_ok ? ST_READ : ST_DONE;
        end
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    alloc_d   = alloc_q;
    lvl_d     = lvl_q;
    tbl_d     = tbl_q;
    item_d    = item_q;
    res_d     = res_q;
    mem_req_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.en   = 1'b1;
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = clr_q;
        clr_d          = clr_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          item_d = item_i;
          lvl_d  = LVL_ROOT;
          tbl_d  = root_ext[TBL_W-1:0];
          res_d  = '0;
        end
      end
      ST_READ: begin
        mem_req_o.en   = 1'b1;
        mem_req_o.addr = cur_addr;
      end
      ST_EVAL: begin
        if (is_leaf) begin
          if (item_q.action == ACT_MAP) begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = cur_addr;
            mem_req_o.wdata = {item_q.phys_addr[PA_W-1:OFF_W], item_q.pte_flags};
          end else if (e_valid) begin
            res_d.result_phys  = {e_ppn, item_q.virt_addr[OFF_W-1:0]};
            res_d.result_flags = mem_rdata_i[FLAG_W-1:0];
            res_d.mapped       = 1'b1;
          end
        end else if (!e_valid) begin
          if (item_q.action == ACT_MAP) begin
            if (pool_full) begin
              res_d.status = 1'b1;
            end else begin
              mem_req_o.en    = 1'b1;
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = cur_addr;
              mem_req_o.wdata = new_pte;
              alloc_d         = alloc_q + ALLOC_W'(1);
              tbl_d           = alloc_q[TBL_W-1:0];
              lvl_d           = lvl_q - LVL_W'(1);
            end
          end
        end else if (nxt_ok) begin
          tbl_d = nxt[TBL_W-1:0];
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      alloc_q <= ALLOC_W'(1);
      lvl_q   <= LVL_ROOT;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      alloc_q <= alloc_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_q  <= tbl_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = state_q == ST_DONE;
  assign result_o       = res_q;

endmodule

[rtl/core/sv39_page_table_walker.sv]
// Top level of the Sv39 page table walker
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------
//  command  | start / busy                  | item_i   (ptw_in_t)
//  result   | result_valid_o, 1-cycle pulse | result_o (ptw_out_t)
//  config   | APB psel/penable/pwrite       | paddr, pwdata, prdata
//
// A full walk makes three dependent reads of the single-port store, each
// in a read state followed by an evaluate state, then a result state.
// Early misses finish sooner. After reset a clearing pass zeroes the
// store; busy is high meanwhile, config writes are taken. Results cannot
// be stalled.
`timescale 1ns / 1ps

module sv39_page_table_walker
  import ptw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ptw_in_t           item_i,
  output logic              result_valid_o,
  output ptw_out_t          result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ptw_cfg_t         cfg;
  ptw_mem_req_t     mem_req;
  logic [PTE_W-1:0] mem_rdata;

  ptw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptw_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ptw_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_i          (cfg),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[rtl/core/ptw_checker.sv]
// Port-level checker for the Sv39 page table walker, bound to the top
`timescale 1ns / 1ps
`include "sv39_page_table_walker_macros.svh"

module ptw_checker
  import ptw_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input ptw_out_t result_o
);

  logic miss_data;

  assign miss_data = (result_o.result_flags != '0) || (result_o.result_phys != '0);

  `PTW_ASSERT_NXT(a_accept_busy, start && !busy, busy, "transfer did not raise busy")
  `PTW_ASSERT_IMP(a_result_in_busy, result_valid_o, busy, "result outside a busy walk")
  `PTW_ASSERT_NXT(a_single_result, result_valid_o, !result_valid_o, "result repeated")
  `PTW_ASSERT_IMP(a_miss_zero, result_valid_o && !result_o.mapped, !miss_data, "miss carries data")

endmodule

bind sv39_page_table_walker ptw_checker u_ptw_checker (.*);

[tb/sv39_page_table_walker_tb.sv]
// Self-checking testbench for the Sv39 page table walker: lookups and maps under APB configuration
`timescale 1ns / 1ps

module sv39_page_table_walker_tb
  import ptw_pkg::*;
;

  localparam int ENTRIES = 512;
  localparam logic [APB_AW-1:0] ADDR_ROOT = 4'h0;
  localparam logic [APB_AW-1:0] ADDR_BASE = 4'h8;
  localparam logic [PPN_W-1:0] BASE_MAX = {PPN_W{1'b1}};
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 238;

  class walk_scoreboard;
    logic [PTE_W-1:0] pte_store [NUM_TABLES*ENTRIES];
    int unsigned next_table;
    logic [ROOT_W-1:0] root;
    logic [PPN_W-1:0] base;
    ptw_out_t expected_q[$];
    int unsigned mismatches;

    function new();
      foreach (pte_store[i]) pte_store[i] = '0;
      next_table = 1;
      root = '0;
      base = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic cfg_idx, logic [APB_DW-1:0] value);
      if (cfg_idx == CFG_ROOT) root = value[ROOT_W-1:0];
      else base = value[PPN_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // walk the shadow tables and queue the result the walker should give
    function void note_command(ptw_in_t c);
      ptw_out_t r;
      int unsigned tbl;
      logic [PTE_W-1:0] e;
      logic [PPN_W-1:0] nxt;
      logic [VPN_W-1:0] idx;
      bit stop;
      r = '0;
      stop = 1'b0;
      tbl = root;
      if (tbl >= NUM_TABLES) stop = 1'b1;
      for (int lvl = 2; lvl >= 1; lvl--) begin
        if (!stop) begin
          idx = c.virt_addr[OFF_W + VPN_W*lvl +: VPN_W];
          e = pte_store[tbl*ENTRIES + int'(idx)];
          if (!e[0]) begin
            if (c.action == ACT_LOOKUP) begin
              stop = 1'b1;
            end else if (next_table >= NUM_TABLES) begin
              r.status = 1'b1;
              stop = 1'b1;
            end else begin
              e = {base + PPN_W'(next_table), FLAG_W'(1)};
              pte_store[tbl*ENTRIES + int'(idx)] = e;
              next_table++;
            end
          end
          if (!stop) begin
            nxt = e[PTE_W-1:FLAG_W] - base;
            if (nxt >= NUM_TABLES) stop = 1'b1;
            else tbl = int'(nxt);
          end
        end
      end
      if (!stop) begin
        idx = c.virt_addr[OFF_W +: VPN_W];
        if (c.action == ACT_MAP) begin
          pte_store[tbl*ENTRIES + int'(idx)] = {c.phys_addr[OFF_W +: PPN_W], c.pte_flags};
        end else begin
          e = pte_store[tbl*ENTRIES + int'(idx)];
          if (e[0]) begin
            r.result_phys  = {e[PTE_W-1:FLAG_W], c.virt_addr[OFF_W-1:0]};
            r.result_flags = e[FLAG_W-1:0];
            r.mapped       = 1'b1;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h got %h", $realtime, what, want, got);
    endfunction

    function void check_result(ptw_out_t got);
      ptw_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, 64'(got.result_phys));
        return;
      end
      want = expected_q.pop_front();
      if (got.result_phys !== want.result_phys)
        report("result_phys", 64'(want.result_phys), 64'(got.result_phys));
      if (got.result_flags !== want.result_flags)
        report("result_flags", 64'(want.result_flags), 64'(got.result_flags));
      if (got.mapped !== want.mapped)
        report("mapped", 64'(want.mapped), 64'(got.mapped));
      if (got.status !== want.status)
        report("status", 64'(want.status), 64'(got.status));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start;
  logic              busy;
  ptw_in_t           item;
  logic              result_valid_o;
  ptw_out_t          result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  walk_scoreboard sb = new();
  int unsigned sent = 0;

  sv39_page_table_walker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.note_command(item);
    end
  end

  function automatic ptw_in_t make_command(logic act, logic [VA_W-1:0] va,
                                           logic [PA_W-1:0] pa, logic [FLAG_W-1:0] fl);
    ptw_in_t c;
    c.action    = act;
    c.virt_addr = va;
    c.phys_addr = pa;
    c.pte_flags = fl;
    return c;
  endfunction

  // mostly a small working set of table paths so lookups hit; some fully random noise
  function automatic ptw_in_t random_command();
    ptw_in_t c;
    logic [VPN_W-1:0] vpn2, vpn1, vpn0;
    c.action = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 10) begin
      c.virt_addr = VA_W'({$urandom, $urandom});
    end else begin
      vpn2 = VPN_W'($urandom_range(0, 3) * 170);
      vpn1 = VPN_W'($urandom_range(0, 3) * 170);
      if ($urandom_range(0, 99) < 75) vpn0 = VPN_W'($urandom_range(0, 7) * 73);
      else vpn0 = VPN_W'($urandom);
      c.virt_addr = {vpn2, vpn1, vpn0, OFF_W'($urandom)};
    end
    if ($urandom_range(0, 99) < 25)
      c.phys_addr = PA_W'({$urandom_range(0, NUM_TABLES - 1), OFF_W'($urandom)});
    else
      c.phys_addr = PA_W'({$urandom, $urandom});
    c.pte_flags = FLAG_W'($urandom);
    if ($urandom_range(0, 99) < 85) c.pte_flags[0] = 1'b1;
    return c;
  endfunction

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    item <= ptw_in_t'({$urandom, $urandom, $urandom, $urandom});
    repeat (n) @(posedge clk_i);
  endtask

  task automatic issue_command(ptw_in_t c);
    start <= 1'b1;
    item <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic pace();
    if ((sent < 300 || sent >= 500) && $urandom_range(0, 99) < 24)
      idle_for($urandom_range(1, 6));
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    idle_for(1);
    while (sb.pending() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(addr == ADDR_BASE ? CFG_BASE : CFG_ROOT, data);
  endtask

  task automatic configure(logic [ROOT_W-1:0] root, logic [PPN_W-1:0] base);
    write_register(ADDR_ROOT, APB_DW'(root));
    write_register(ADDR_BASE, APB_DW'(base));
  endtask

  task automatic run_directed();
    issue_command(make_command(ACT_LOOKUP, '0, '0, '0));
    issue_command(make_command(ACT_MAP, '0, PA_W'(56'h3F000), 10'h3CF));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'h123), '0, '0));
    issue_command(make_command(ACT_MAP, {VA_W{1'b1}}, {PA_W{1'b1}}, {FLAG_W{1'b1}}));
    issue_command(make_command(ACT_LOOKUP, {VA_W{1'b1}}, '0, '0));
    issue_command(make_command(ACT_MAP, VA_W'(39'h1000), PA_W'(56'h7000), 10'h3FE));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'h1000), '0, '0));
    issue_command(make_command(ACT_MAP, VA_W'(39'h2000), '0, 10'h001));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'h2FFF), '0, '0));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'h2000), {PA_W{1'b1}}, {FLAG_W{1'b1}}));
    issue_command(make_command(ACT_MAP, '0, PA_W'(56'h5000), 10'h0C1));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'hABC), '0, '0));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'h1) << 21, '0, '0));
    issue_command(make_command(ACT_LOOKUP, VA_W'(39'h1) << 30, '0, '0));
    issue_command(make_command(ACT_MAP, VA_W'(39'h1FF) << 30, PA_W'(56'h2000), 10'h00F));
    issue_command(make_command(ACT_LOOKUP, (VA_W'(39'h1FF) << 30) | VA_W'(39'hFFF), '0, '0));
  endtask

  initial begin
    logic [ROOT_W-1:0] roots [PHASES];
    logic [PPN_W-1:0] bases [PHASES];
    roots = '{6'd0, 6'd63, 6'd0, 6'd0, 6'd0, 6'd2};
    bases = '{'0, '0, BASE_MAX, '0, '0, '0};
    roots[3] = ROOT_W'($urandom_range(0, NUM_TABLES - 1));
    bases[3] = PPN_W'({$urandom, $urandom});
    start <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < PHASES; p++) begin
      configure(roots[p], bases[p]);
      if (p == 0) run_directed();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pace();
        issue_command(random_command());
      end
      wait_drained();
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
